/* rtl/spi_nor_flash_command_sequencer_top_macros.svh */
// assertion macros used by the checker of the command sequencer
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SNOR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SNOR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/snor_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package snor_pkg;

    // flash geometry
    localparam int PageBytes = 256;
    localparam int PageLog   = $clog2(PageBytes);
    localparam int ChunkW    = PageLog + 1;
    localparam int AddrBits  = 24;
    localparam int AddrBytes = (AddrBits + 7) / 8;
    localparam int AddrPadW  = AddrBytes * 8;

    // item fields
    localparam int OpW       = 3;
    localparam int AddrInW   = 24;
    localparam int CountW    = 25;
    localparam int ByteW     = 8;
    localparam int KindW     = 2;
    localparam int InDataW   = 64;
    localparam int OutDataW  = 16;
    localparam int InAddrLo  = 0;
    localparam int InCountLo = InAddrLo + AddrInW;
    localparam int InDataLo  = InCountLo + CountW;
    localparam int InUsedW   = InDataLo + ByteW;
    localparam int EndSelBit = ByteW;

    // result list per input item and queue between front and back
    localparam int MaxSlots  = 8;
    localparam int SlotIdxW  = $clog2(MaxSlots);
    localparam int SlotCntW  = SlotIdxW + 1;
    localparam int QDepth    = 2;
    localparam int QPtrW     = $clog2(QDepth);
    localparam int QCntW     = QPtrW + 1;

    // request codes
    localparam logic [OpW-1:0] OP_READ         = 3'd0;
    localparam logic [OpW-1:0] OP_WRITE        = 3'd1;
    localparam logic [OpW-1:0] OP_SECTOR_ERASE = 3'd2;
    localparam logic [OpW-1:0] OP_CHIP_ERASE   = 3'd3;
    localparam logic [OpW-1:0] OP_ID_READ      = 3'd4;
    localparam logic [OpW-1:0] OP_HOST_BYTE    = 3'd5;
    localparam logic [OpW-1:0] OP_FLASH_BYTE   = 3'd6;

    // result kinds
    localparam logic [KindW-1:0] K_SEND = 2'd0;
    localparam logic [KindW-1:0] K_SLOT = 2'd1;
    localparam logic [KindW-1:0] K_HOST = 2'd2;
    localparam logic [KindW-1:0] K_DONE = 2'd3;

    // flash opcodes
    localparam logic [ByteW-1:0] CMD_READ    = 8'h03;
    localparam logic [ByteW-1:0] CMD_PROGRAM = 8'h02;
    localparam logic [ByteW-1:0] CMD_WREN    = 8'h06;
    localparam logic [ByteW-1:0] CMD_RDSR    = 8'h05;
    localparam logic [ByteW-1:0] CMD_SE      = 8'h20;
    localparam logic [ByteW-1:0] CMD_CE      = 8'hC7;
    localparam logic [ByteW-1:0] CMD_RDID    = 8'h9F;

    // write-in-progress bit of the status register
    localparam int WipBit = 0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READ,
        PH_WDATA,
        PH_POLL,
        PH_ID
    } t_phase;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] value;
        logic             end_sel;
    } t_slot;

    typedef struct packed {
        logic [SlotIdxW-1:0]       last_idx;
        t_slot [MaxSlots-1:0]      slot;
    } t_script;

    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_stat;

    function automatic t_slot mk_slot(input logic [KindW-1:0] kind,
                                      input logic [ByteW-1:0] value,
                                      input logic             end_sel);
        t_slot s;
        s.kind    = kind;
        s.value   = value;
        s.end_sel = end_sel;
        return s;
    endfunction

    // bytes of the next frame: up to the page end, at most what is left
    function automatic logic [ChunkW-1:0] chunk_of(input logic [AddrBits-1:0] addr,
                                                   input logic [CountW-1:0]   rem);
        logic [ChunkW-1:0] room;
        room = ChunkW'(PageBytes) - {1'b0, addr[PageLog-1:0]};
        if (rem < CountW'(room)) begin
            return rem[ChunkW-1:0];
        end
        return room;
    endfunction

endpackage
`default_nettype wire

/* rtl/snor_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module snor_front
    import snor_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [OpW-1:0]      i_op,
    input  wire logic [AddrBits-1:0] i_addr,
    input  wire logic [CountW-1:0]   i_count,
    input  wire logic [ByteW-1:0]    i_data,
    input  wire t_q_stat             i_q_stat,
    output logic                     o_push,
    output t_script                  o_script
);

    t_phase              r_phase,      n_phase;
    logic [OpW-1:0]      r_req_kind,   n_req_kind;
    logic [AddrBits-1:0] r_cur_addr,   n_cur_addr;
    logic [CountW-1:0]   r_remaining,  n_remaining;
    logic [ChunkW-1:0]   r_chunk_left, n_chunk_left;

    logic                take;
    logic                cnt_zero;
    logic [ChunkW-1:0]   adv_chunk;
    logic [CountW-1:0]   adv_rem;
    logic [AddrBits-1:0] adv_addr;

    assign o_in_ready = !i_q_stat.full;
    assign take       = i_in_valid && o_in_ready;
    assign cnt_zero   = (i_count == '0);
    assign adv_chunk  = r_chunk_left - 1'b1;
    assign adv_rem    = r_remaining - 1'b1;
    assign adv_addr   = r_cur_addr + 1'b1;

    always_comb begin : next_state
        n_phase = r_phase;
        if (take) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_op == OP_READ) begin
                        n_phase = cnt_zero ? PH_IDLE : PH_READ;
                    end else if (i_op == OP_WRITE) begin
                        n_phase = cnt_zero ? PH_IDLE : PH_WDATA;
                    end else if (i_op == OP_SECTOR_ERASE || i_op == OP_CHIP_ERASE) begin
                        n_phase = PH_POLL;
                    end else if (i_op == OP_ID_READ) begin
                        n_phase = cnt_zero ? PH_IDLE : PH_ID;
                    end
                end
                PH_WDATA: begin
                    if (i_op == OP_HOST_BYTE && adv_chunk == '0) n_phase = PH_POLL;
                end
                PH_READ: begin
                    if (i_op == OP_FLASH_BYTE && adv_chunk == '0 && adv_rem == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_ID: begin
                    if (i_op == OP_FLASH_BYTE && adv_rem == '0) n_phase = PH_IDLE;
                end
                PH_POLL: begin
                    if (i_op == OP_FLASH_BYTE && !i_data[WipBit]) begin
                        n_phase = (r_req_kind == OP_WRITE && r_remaining != '0) ?
                                  PH_WDATA : PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin : outputs
        logic [SlotCntW-1:0] k;
        logic [ChunkW-1:0]   ch;
        logic [AddrPadW-1:0] ax;
        k            = '0;
        ch           = '0;
        ax           = '0;
        o_script     = '0;
        n_req_kind   = r_req_kind;
        n_cur_addr   = r_cur_addr;
        n_remaining  = r_remaining;
        n_chunk_left = r_chunk_left;
        if (take) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_op <= OP_ID_READ) begin
                        n_req_kind   = i_op;
                        n_cur_addr   = i_addr;
                        n_remaining  = i_count;
                        n_chunk_left = '0;
                        ax           = AddrPadW'(i_addr);
                        ch           = chunk_of(i_addr, i_count);
                    end
                    case (i_op) inside
                        OP_READ: begin
                            if (cnt_zero) begin
                                o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_DONE, '0, 1'b0);
                                k = k + 1'b1;
                            end else begin
                                n_chunk_left = ch;
                                o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_READ, 1'b0);
                                k = k + 1'b1;
                                for (int i = AddrBytes - 1; i >= 0; i--) begin
                                    o_script.slot[k[SlotIdxW-1:0]] =
                                        mk_slot(K_SEND, ax[8*i +: 8], 1'b0);
                                    k = k + 1'b1;
                                end
                                o_script.slot[k[SlotIdxW-1:0]] =
                                    mk_slot(K_SLOT, '0, ch == ChunkW'(1));
                                k = k + 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            if (cnt_zero) begin
                                o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_DONE, '0, 1'b0);
                                k = k + 1'b1;
                            end else begin
                                n_chunk_left = ch;
                                o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_WREN, 1'b1);
                                k = k + 1'b1;
                                o_script.slot[k[SlotIdxW-1:0]] =
                                    mk_slot(K_SEND, CMD_PROGRAM, 1'b0);
                                k = k + 1'b1;
                                for (int i = AddrBytes - 1; i >= 0; i--) begin
                                    o_script.slot[k[SlotIdxW-1:0]] =
                                        mk_slot(K_SEND, ax[8*i +: 8], 1'b0);
                                    k = k + 1'b1;
                                end
                            end
                        end
                        [OP_SECTOR_ERASE:OP_CHIP_ERASE]: begin
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_WREN, 1'b1);
                            k = k + 1'b1;
                            if (i_op == OP_SECTOR_ERASE) begin
                                o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_SE, 1'b0);
                                k = k + 1'b1;
                                for (int i = AddrBytes - 1; i >= 0; i--) begin
                                    o_script.slot[k[SlotIdxW-1:0]] =
                                        mk_slot(K_SEND, ax[8*i +: 8], i == 0);
                                    k = k + 1'b1;
                                end
                            end else begin
                                o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_CE, 1'b1);
                                k = k + 1'b1;
                            end
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_RDSR, 1'b0);
                            k = k + 1'b1;
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SLOT, '0, 1'b1);
                            k = k + 1'b1;
                        end
                        OP_ID_READ: begin
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_RDID, cnt_zero);
                            k = k + 1'b1;
                            if (cnt_zero) begin
                                o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_DONE, '0, 1'b0);
                            end else begin
                                o_script.slot[k[SlotIdxW-1:0]] =
                                    mk_slot(K_SLOT, '0, i_count == CountW'(1));
                            end
                            k = k + 1'b1;
                        end
                        default: ;
                    endcase
                end
                PH_WDATA: begin
                    if (i_op == OP_HOST_BYTE) begin
                        o_script.slot[k[SlotIdxW-1:0]] =
                            mk_slot(K_SEND, i_data, r_chunk_left <= ChunkW'(1));
                        k = k + 1'b1;
                        n_chunk_left = adv_chunk;
                        n_remaining  = adv_rem;
                        n_cur_addr   = adv_addr;
                        if (adv_chunk == '0) begin
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_RDSR, 1'b0);
                            k = k + 1'b1;
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SLOT, '0, 1'b1);
                            k = k + 1'b1;
                        end
                    end
                end
                PH_READ: begin
                    if (i_op == OP_FLASH_BYTE) begin
                        o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_HOST, i_data, 1'b0);
                        k = k + 1'b1;
                        n_chunk_left = adv_chunk;
                        n_remaining  = adv_rem;
                        n_cur_addr   = adv_addr;
                        if (adv_chunk != '0) begin
                            o_script.slot[k[SlotIdxW-1:0]] =
                                mk_slot(K_SLOT, '0, adv_chunk == ChunkW'(1));
                            k = k + 1'b1;
                        end else if (adv_rem != '0) begin
                            // next page: open a new read frame
                            ch           = chunk_of(adv_addr, adv_rem);
                            ax           = AddrPadW'(adv_addr);
                            n_chunk_left = ch;
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_READ, 1'b0);
                            k = k + 1'b1;
                            for (int i = AddrBytes - 1; i >= 0; i--) begin
                                o_script.slot[k[SlotIdxW-1:0]] =
                                    mk_slot(K_SEND, ax[8*i +: 8], 1'b0);
                                k = k + 1'b1;
                            end
                            o_script.slot[k[SlotIdxW-1:0]] =
                                mk_slot(K_SLOT, '0, ch == ChunkW'(1));
                            k = k + 1'b1;
                        end else begin
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_DONE, '0, 1'b0);
                            k = k + 1'b1;
                        end
                    end
                end
                PH_ID: begin
                    if (i_op == OP_FLASH_BYTE) begin
                        o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_HOST, i_data, 1'b0);
                        k = k + 1'b1;
                        n_remaining = adv_rem;
                        if (adv_rem != '0) begin
                            o_script.slot[k[SlotIdxW-1:0]] =
                                mk_slot(K_SLOT, '0, adv_rem == CountW'(1));
                        end else begin
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_DONE, '0, 1'b0);
                        end
                        k = k + 1'b1;
                    end
                end
                PH_POLL: begin
                    if (i_op == OP_FLASH_BYTE) begin
                        if (i_data[WipBit]) begin
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_RDSR, 1'b0);
                            k = k + 1'b1;
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SLOT, '0, 1'b1);
                            k = k + 1'b1;
                        end else if (r_req_kind == OP_WRITE && r_remaining != '0) begin
                            // next page program, with its own write enable
                            ch           = chunk_of(r_cur_addr, r_remaining);
                            ax           = AddrPadW'(r_cur_addr);
                            n_chunk_left = ch;
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_WREN, 1'b1);
                            k = k + 1'b1;
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_SEND, CMD_PROGRAM, 1'b0);
                            k = k + 1'b1;
                            for (int i = AddrBytes - 1; i >= 0; i--) begin
                                o_script.slot[k[SlotIdxW-1:0]] =
                                    mk_slot(K_SEND, ax[8*i +: 8], 1'b0);
                                k = k + 1'b1;
                            end
                        end else begin
                            o_script.slot[k[SlotIdxW-1:0]] = mk_slot(K_DONE, '0, 1'b0);
                            k = k + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        o_script.last_idx = SlotIdxW'(k - 1'b1);
        o_push            = take && (k != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_req_kind   <= '0;
            r_cur_addr   <= '0;
            r_remaining  <= '0;
            r_chunk_left <= '0;
        end else begin
            r_phase      <= n_phase;
            r_req_kind   <= n_req_kind;
            r_cur_addr   <= n_cur_addr;
            r_remaining  <= n_remaining;
            r_chunk_left <= n_chunk_left;
        end
    end

endmodule
`default_nettype wire

/* rtl/snor_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module snor_queue
    import snor_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_script i_script,
    input  wire logic    i_pop,
    output t_script      o_head,
    output t_q_stat      o_stat
);

    t_script           r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr;
    logic [QPtrW-1:0]  r_rd;
    logic [QCntW-1:0]  r_cnt;

    assign o_head            = r_mem[r_rd];
    assign o_stat.head_valid = (r_cnt != '0);
    assign o_stat.full       = (r_cnt == QCntW'(QDepth));

    // entries carry no reset
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_script;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/snor_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module snor_back
    import snor_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_script           i_head,
    input  wire t_q_stat           i_q_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [KindW-1:0]       o_kind,
    output logic [ByteW-1:0]       o_byte,
    output logic                   o_end_sel,
    output logic                   o_last
);

    logic                r_valid;
    logic [SlotIdxW-1:0] r_idx;
    logic [KindW-1:0]    r_kind;
    logic [ByteW-1:0]    r_byte;
    logic                r_end_sel;
    logic                r_last;

    logic                load;
    logic                at_last;
    t_slot               cur;

    assign load    = !r_valid || i_ready;
    assign cur     = i_head.slot[r_idx];
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && i_q_stat.head_valid && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_q_stat.head_valid;
            if (i_q_stat.head_valid) begin
                r_idx <= at_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= cur.kind;
            r_byte    <= cur.value;
            r_end_sel <= cur.end_sel;
            r_last    <= at_last;
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_byte    = r_byte;
    assign o_end_sel = r_end_sel;
    assign o_last    = r_last;

endmodule
`default_nettype wire

/* rtl/spi_nor_flash_command_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// serial nor flash command sequencer
// input stream: one item per host request (read, page program, sector erase,
//   chip erase, id read), per host payload byte, or per byte received from
//   the flash; tuser carries the op code, tdata the address, count and byte
// output stream: byte slots for the flash (send byte, receive slot request),
//   bytes returned to the host and request done; tuser carries the kind,
//   tdata the byte and the chip-select release flag, tlast marks the last
//   result caused by one input item
// an input item causes zero to seven results; the front classifies it and
//   updates the request state in the cycle it is accepted, then queues its
//   result list; the back drains the list one result per cycle while the
//   receiver is ready; when nothing is queued ahead of an item, its first
//   result passes through its queue entry and then the output register
// throughput: the front takes one item per cycle while the two-entry queue
//   has room; the sustained rate is set by the single output register of
//   the back end
// a stalled receiver holds the output register; the queue fills and then
//   tready drops on the input side
// reset (synchronous, active low) returns to idle with an empty queue and
//   no result pending
module spi_nor_flash_command_sequencer_top
    import snor_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [InDataW-1:0]  i_s_tdata,   // addr[23:0], count[48:24], data[56:49]
    input  wire logic [OpW-1:0]      i_s_tuser,   // op[2:0]
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [OutDataW-1:0]      o_m_tdata,   // byte_value[7:0], end_select[8]
    output logic [KindW-1:0]         o_m_tuser,   // kind[1:0]
    output logic                     o_m_tlast    // last
);

    // input field unpacking
    logic [AddrBits-1:0] in_addr;
    logic [CountW-1:0]   in_count;
    logic [ByteW-1:0]    in_data;

    assign in_addr  = i_s_tdata[InAddrLo +: AddrBits];
    assign in_count = i_s_tdata[InCountLo +: CountW];
    assign in_data  = i_s_tdata[InDataLo +: ByteW];

    // front to queue to back
    logic    push;
    logic    pop;
    t_script front_script;
    t_script head;
    t_q_stat q_stat;

    logic [ByteW-1:0] out_byte;
    logic             out_end_sel;

    snor_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_op       (i_s_tuser),
        .i_addr     (in_addr),
        .i_count    (in_count),
        .i_data     (in_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_script   (front_script)
    );

    snor_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_script (front_script),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (q_stat)
    );

    snor_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (o_m_tuser),
        .o_byte    (out_byte),
        .o_end_sel (out_end_sel),
        .o_last    (o_m_tlast)
    );

    // output packing, zero filled to whole bytes
    assign o_m_tdata = {(OutDataW - ByteW - 1)'(0), out_end_sel, out_byte};

endmodule
`default_nettype wire

/* rtl/snor_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "spi_nor_flash_command_sequencer_top_macros.svh"
module snor_checker
    import snor_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_m_tvalid,
    input wire logic                i_m_tready,
    input wire logic [OutDataW-1:0] o_m_tdata,
    input wire logic [KindW-1:0]    o_m_tuser,
    input wire logic                o_m_tlast
);

    // a stalled result holds
`SNOR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "output changed while stalled")

    // host bytes and done never release chip select
`SNOR_ASSERT_IMP(a_no_sel_end, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == K_HOST || o_m_tuser == K_DONE), !o_m_tdata[EndSelBit], "end_select set on host byte or done")

    // slot requests and done carry a zero byte
`SNOR_ASSERT_IMP(a_zero_byte, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == K_SLOT || o_m_tuser == K_DONE), o_m_tdata[ByteW-1:0] == '0, "nonzero byte on slot request or done")

    // done closes the result list of its item
`SNOR_ASSERT_IMP(a_done_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == K_DONE, o_m_tlast, "request done not marked last")

endmodule

bind spi_nor_flash_command_sequencer_top snor_checker u_snor_checker (.*);
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import snor_pkg::*;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [InDataW-1:0]   i_s_tdata  = '0;   // addr[23:0], count[48:24], data[56:49]
    logic [OpW-1:0]       i_s_tuser  = '0;   // op[2:0]
    logic                 i_m_tready = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [OutDataW-1:0]  o_m_tdata;         // byte_value[7:0], end_select[8]
    logic [KindW-1:0]     o_m_tuser;         // kind[1:0]
    logic                 o_m_tlast;

    // one byte slot or event leaving the sequencer
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] value;
        logic             end_sel;
        logic             is_last;
    } flash_slot_t;

    // mirror of the request state plus the byte slots still owed by the block
    class flash_cmd_scoreboard;
        t_phase              phase;
        logic [OpW-1:0]      req_op;
        logic [AddrBits-1:0] addr_ptr;
        logic [CountW-1:0]   left_total;
        logic [ChunkW-1:0]   left_in_page;
        flash_slot_t         owed_slots[$];
        flash_slot_t         batch[$];
        int                  errors;
        int                  results_checked;
        int                  n_ignored;
        int                  n_requests[5];
        int                  n_page_frames;

        function new();
            phase         = PH_IDLE;
            req_op        = '0;
            addr_ptr      = '0;
            left_total    = '0;
            left_in_page  = '0;
            errors        = 0;
            results_checked = 0;
            n_ignored     = 0;
            n_page_frames = 0;
            foreach (n_requests[i]) n_requests[i] = 0;
        endfunction

        function void add_slot(logic [KindW-1:0] kind, logic [ByteW-1:0] value,
                               logic end_sel);
            flash_slot_t s;
            s.kind    = kind;
            s.value   = value;
            s.end_sel = end_sel;
            s.is_last = 1'b0;
            batch.push_back(s);
        endfunction

        // address goes out most significant byte first
        function void send_address_bytes(logic end_on_last);
            for (int i = AddrBytes - 1; i >= 0; i--) begin
                add_slot(K_SEND, ByteW'(addr_ptr >> (8 * i)), (i == 0) ? end_on_last : 1'b0);
            end
        endfunction

        // bytes up to the page end, but no more than what is left
        function logic [ChunkW-1:0] page_chunk();
            int room;
            room = PageBytes - int'(addr_ptr % PageBytes);
            if (int'(left_total) < room) return ChunkW'(left_total);
            return ChunkW'(room);
        endfunction

        function void open_read_frame();
            left_in_page = page_chunk();
            n_page_frames++;
            add_slot(K_SEND, CMD_READ, 1'b0);
            send_address_bytes(1'b0);
            add_slot(K_SLOT, '0, left_in_page == 1);
            phase = PH_READ;
        endfunction

        // every page program gets its own write enable frame
        function void open_program_frame();
            left_in_page = page_chunk();
            n_page_frames++;
            add_slot(K_SEND, CMD_WREN, 1'b1);
            add_slot(K_SEND, CMD_PROGRAM, 1'b0);
            send_address_bytes(1'b0);
            phase = PH_WDATA;
        endfunction

        function void start_status_poll();
            add_slot(K_SEND, CMD_RDSR, 1'b0);
            add_slot(K_SLOT, '0, 1'b1);
            phase = PH_POLL;
        endfunction

        function void close_request();
            add_slot(K_DONE, '0, 1'b0);
            phase = PH_IDLE;
        endfunction

        function void step_address();
            left_in_page--;
            left_total--;
            addr_ptr++;
        endfunction

        // works out the results of one accepted item, returns how many
        function int note_input(logic [OpW-1:0] op, logic [AddrInW-1:0] addr_in,
                                logic [CountW-1:0] count, logic [ByteW-1:0] data);
            batch.delete();
            case (op)
                OP_READ, OP_WRITE, OP_SECTOR_ERASE, OP_CHIP_ERASE, OP_ID_READ: begin
                    if (phase == PH_IDLE) begin
                        n_requests[op]++;
                        req_op       = op;
                        addr_ptr     = addr_in[AddrBits-1:0];
                        left_total   = count;
                        left_in_page = '0;
                        case (op)
                            OP_READ: begin
                                if (count == 0) close_request();
                                else open_read_frame();
                            end
                            OP_WRITE: begin
                                if (count == 0) close_request();
                                else open_program_frame();
                            end
                            OP_SECTOR_ERASE: begin
                                add_slot(K_SEND, CMD_WREN, 1'b1);
                                add_slot(K_SEND, CMD_SE, 1'b0);
                                send_address_bytes(1'b1);
                                start_status_poll();
                            end
                            OP_CHIP_ERASE: begin
                                add_slot(K_SEND, CMD_WREN, 1'b1);
                                add_slot(K_SEND, CMD_CE, 1'b1);
                                start_status_poll();
                            end
                            default: begin
                                add_slot(K_SEND, CMD_RDID, count == 0);
                                if (count == 0) begin
                                    close_request();
                                end else begin
                                    add_slot(K_SLOT, '0, count == 1);
                                    phase = PH_ID;
                                end
                            end
                        endcase
                    end
                end
                OP_HOST_BYTE: begin
                    if (phase == PH_WDATA) begin
                        add_slot(K_SEND, data, left_in_page <= 1);
                        step_address();
                        if (left_in_page == 0) start_status_poll();
                    end
                end
                OP_FLASH_BYTE: begin
                    case (phase)
                        PH_READ: begin
                            add_slot(K_HOST, data, 1'b0);
                            step_address();
                            if (left_in_page != 0) add_slot(K_SLOT, '0, left_in_page == 1);
                            else if (left_total != 0) open_read_frame();
                            else close_request();
                        end
                        PH_ID: begin
                            add_slot(K_HOST, data, 1'b0);
                            left_total--;
                            if (left_total != 0) add_slot(K_SLOT, '0, left_total == 1);
                            else close_request();
                        end
                        PH_POLL: begin
                            if (data[WipBit]) start_status_poll();
                            else if (req_op == OP_WRITE && left_total != 0) open_program_frame();
                            else close_request();
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (batch.size() == 0) begin
                n_ignored++;
                return 0;
            end
            batch[batch.size() - 1].is_last = 1'b1;
            foreach (batch[i]) owed_slots.push_back(batch[i]);
            return batch.size();
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual) begin
                $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
                errors++;
            end
        endfunction

        function void check_result(logic [KindW-1:0] kind, logic [ByteW-1:0] value,
                                   logic end_sel, logic is_last);
            flash_slot_t exp_slot;
            if ($isunknown({kind, value, end_sel, is_last})) begin
                $error("result with unknown bits: kind %b value %b end_select %b last %b",
                       kind, value, end_sel, is_last);
                errors++;
                return;
            end
            if (owed_slots.size() == 0) begin
                $error("result with nothing expected: kind %0d value %0h end_select %0d last %0d",
                       kind, value, end_sel, is_last);
                errors++;
                return;
            end
            exp_slot = owed_slots.pop_front();
            results_checked++;
            compare_field("kind", exp_slot.kind, kind);
            compare_field("byte_value", exp_slot.value, value);
            compare_field("end_select", exp_slot.end_sel, end_sel);
            compare_field("last", exp_slot.is_last, is_last);
        endfunction

        function int pending();
            return owed_slots.size();
        endfunction
    endclass

    flash_cmd_scoreboard sb = new();

    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    spi_nor_flash_command_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // receiver: switches between always ready, coin flip, heavy stall and a fixed rhythm
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 120);
        end else begin
            stall_span <= stall_span - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 1) == 1);
            2:       i_m_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_tready <= ((stall_tick % 5) < 3);
        endcase
    end

    // results are taken at the edge where valid and ready meet
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tuser, o_m_tdata[ByteW-1:0], o_m_tdata[EndSelBit], o_m_tlast);
        end
    end

    // one item onto the input stream, with random gaps between bursts
    task automatic offer_item(input logic [OpW-1:0] op, input logic [AddrInW-1:0] a,
                              input logic [CountW-1:0] n, input logic [ByteW-1:0] d,
                              output int produced);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(InDataW - InUsedW){1'b0}}, d, n, a};
        do @(posedge i_clk); while (!o_s_tready);
        produced = sb.note_input(op, a, n, d);
    endtask

    task automatic put(input logic [OpW-1:0] op, input logic [AddrInW-1:0] a,
                       input logic [CountW-1:0] n, input logic [ByteW-1:0] d);
        int produced;
        offer_item(op, a, n, d, produced);
    endtask

    // sender holds off until every owed slot has come out
    task automatic wait_until_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // well-formed traffic most of the time, stray and busy items now and then
    task automatic random_item(input bit allow_noise, input bit poll_clears,
                               output int produced);
        logic [OpW-1:0]     op;
        logic [AddrInW-1:0] a;
        logic [CountW-1:0]  n;
        logic [ByteW-1:0]   d;
        int                 pick;
        a = AddrInW'($urandom);
        n = CountW'($urandom);
        d = ByteW'($urandom);
        pick = $urandom_range(0, 99);
        if (allow_noise && pick < 12) begin
            // a request while idle would start with a huge count, so only strays then
            if (sb.phase == PH_IDLE) op = OpW'($urandom_range(5, 7));
            else op = OpW'($urandom_range(0, 7));
        end else begin
            case (sb.phase)
                PH_IDLE: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30) op = OP_READ;
                    else if (pick < 60) op = OP_WRITE;
                    else if (pick < 72) op = OP_SECTOR_ERASE;
                    else if (pick < 80) op = OP_CHIP_ERASE;
                    else op = OP_ID_READ;
                    // often start just short of a page end
                    if ($urandom_range(0, 1) == 1)
                        a = AddrInW'(a - (a % PageBytes) + PageBytes - $urandom_range(1, 16));
                    // erases ignore the count, so it keeps its full random value there
                    if (op == OP_READ || op == OP_WRITE || op == OP_ID_READ) begin
                        pick = $urandom_range(0, 19);
                        if (pick == 0) n = '0;
                        else if (pick < 3) n = CountW'($urandom_range(13, 40));
                        else n = CountW'($urandom_range(1, 12));
                    end
                end
                PH_WDATA: op = OP_HOST_BYTE;
                PH_POLL: begin
                    op = OP_FLASH_BYTE;
                    d[WipBit] = poll_clears ? 1'b0 : ($urandom_range(0, 2) == 0);
                end
                default: op = OP_FLASH_BYTE;
            endcase
        end
        offer_item(op, a, n, d, produced);
    endtask

    initial begin
        int produced;
        int useful;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero counts, id read, strays while idle, unused op
        put(OP_READ,  24'h000000, 25'd0, 8'h00);
        put(OP_WRITE, 24'h123456, 25'd0, 8'h00);
        put(OP_ID_READ, 24'h000000, 25'd0, 8'h00);
        put(OP_ID_READ, 24'hFFFFFF, 25'd2, 8'h00);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'hFF);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h00);
        put(OP_HOST_BYTE, 24'h000000, 25'd0, 8'h55);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'hAA);
        put(3'd7, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        // read across a page end and the address wrap, with a busy request and a stray
        put(OP_READ, 24'hFFFFFE, 25'd3, 8'h00);
        put(OP_CHIP_ERASE, 24'h000000, 25'd0, 8'h00);
        put(OP_HOST_BYTE, 24'h000000, 25'd0, 8'h11);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'hA5);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h5A);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'hFF);
        // erases: the sector erase sees status busy once then clear, the chip erase clear at once
        put(OP_SECTOR_ERASE, 24'hFFFFFF, 25'h1FFFFFF, 8'h00);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, ByteW'(1 << WipBit));
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h00);
        put(OP_CHIP_ERASE, 24'h000000, 25'd0, 8'h00);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'hFE);
        // two-page program, write enable again for the second page
        put(OP_WRITE, 24'h0000FF, 25'd2, 8'h00);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h33);
        put(OP_HOST_BYTE, 24'h000000, 25'd0, 8'h00);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h00);
        put(OP_HOST_BYTE, 24'h000000, 25'd0, 8'hFF);
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h80);
        wait_until_drained();

        useful = 0;
        while (useful < 110) begin
            random_item(1'b1, 1'b0, produced);
            if (produced != 0) useful++;
            if ($urandom_range(0, 49) == 0) wait_until_drained();
        end
        while (sb.phase != PH_IDLE) random_item(1'b0, 1'b1, produced);

        // huge program left open: first page, then the address wraps to zero
        put(OP_WRITE, 24'hFFFFF0, 25'h1FFFFFF, 8'h00);
        repeat (16) put(OP_HOST_BYTE, 24'h000000, 25'd0, ByteW'($urandom));
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, ByteW'(1 << WipBit));
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h00);
        // everything below is ignored or lands in the open page
        for (int i = 0; i < 5; i++)
            put(OpW'(i), AddrInW'($urandom), CountW'($urandom), ByteW'($urandom));
        put(OP_FLASH_BYTE, 24'h000000, 25'd0, 8'h00);
        put(3'd7, 24'h000000, 25'd0, 8'h00);
        put(OP_HOST_BYTE, 24'h000000, 25'd0, 8'hC3);

        wait_until_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d reads, %0d programs, %0d sector and %0d chip erases, %0d id reads",
                 sb.n_requests[OP_READ], sb.n_requests[OP_WRITE],
                 sb.n_requests[OP_SECTOR_ERASE], sb.n_requests[OP_CHIP_ERASE],
                 sb.n_requests[OP_ID_READ]);
        $display("%0d page frames, %0d results checked, %0d items ignored by the block",
                 sb.n_page_frames, sb.results_checked, sb.n_ignored);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("timeout with %0d results still owed", sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/snor_pkg.sv
rtl/snor_front.sv
rtl/snor_queue.sv
rtl/snor_back.sv
rtl/spi_nor_flash_command_sequencer_top.sv
rtl/snor_checker.sv
test/testbench.sv
